>>> sv/hcm_pkg.sv
`default_nettype none
package hcm_pkg;

    localparam int OP_W   = 2;
    localparam int KEY_W  = 31;
    localparam int VAL_W  = 32;
    localparam int ST_W   = 2;
    localparam int CFG_W  = 12;
    localparam int RESET_BUCKETS = 16;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    localparam logic [ST_W-1:0] STAT_OK       = 2'd0;
    localparam logic [ST_W-1:0] STAT_DUP      = 2'd1;
    localparam logic [ST_W-1:0] STAT_NOTFOUND = 2'd2;
    localparam logic [ST_W-1:0] STAT_FULL     = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_MOVE_RD,
        ST_MOVE_WR,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic start;
        logic scan_rd;
        logic scan_cmp;
        logic move_rd;
        logic move_wr;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic empty;
        logic last;
        logic match;
        logic op_remove;
        logic out_free;
    } dp_stat_t;

endpackage
`default_nettype wire

>>> sv/hcm_req_if.sv
`default_nettype none
interface hcm_req_if;
    logic                        valid;
    logic                        ready;
    logic [hcm_pkg::OP_W-1:0]    op;
    logic [hcm_pkg::KEY_W-1:0]   key;
    logic [hcm_pkg::VAL_W-1:0]   value;

    modport source (output valid, op, key, value, input ready);
    modport sink (input valid, op, key, value, output ready);
endinterface
`default_nettype wire

>>> sv/hcm_rsp_if.sv
`default_nettype none
interface hcm_rsp_if #(
    parameter int BW = 12,
    parameter int CW = 11
);
    logic                        valid;
    logic                        ready;
    logic [hcm_pkg::ST_W-1:0]    status;
    logic                        found;
    logic [hcm_pkg::VAL_W-1:0]   found_value;
    logic [BW-1:0]               bucket_count;
    logic [CW-1:0]               entry_count;

    modport source (output valid, status, found, found_value, bucket_count, entry_count,
                    input ready);
    modport sink (input valid, status, found, found_value, bucket_count, entry_count,
                  output ready);
endinterface
`default_nettype wire

>>> sv/chained_hash_map_with_resize_core.sv
// Flow: a request on an empty store goes from accept straight to the finish state;
//   else each scanned entry takes a read and a compare state until a match or the
//   last entry, and a remove hit then moves the last entry into the freed slot.
// Throughput: one item at a time; the entry memory scan and an untaken result set the rate.
// Reset: empty store, bucket count 16 (or MAX_BUCKETS if smaller), no clearing pass;
//   a configuration write empties the store at once.
`default_nettype none
module chained_hash_map_with_resize_core #(
    parameter int CAPACITY    = 1024,
    parameter int MAX_BUCKETS = 2048
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [hcm_pkg::CFG_W-1:0] cfg_wdata,
    hcm_req_if.sink                        req,
    hcm_rsp_if.source                      rsp
);

    hcm_pkg::ctrl_cmd_t cmd;
    hcm_pkg::dp_stat_t  stat;

    hcm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    hcm_datapath #(
        .CAPACITY    (CAPACITY),
        .MAX_BUCKETS (MAX_BUCKETS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .in_op            (req.op),
        .in_key           (req.key),
        .in_value         (req.value),
        .out_ready        (rsp.ready),
        .out_valid        (rsp.valid),
        .out_status       (rsp.status),
        .out_found        (rsp.found),
        .out_found_value  (rsp.found_value),
        .out_bucket_count (rsp.bucket_count),
        .out_entry_count  (rsp.entry_count)
    );

endmodule
`default_nettype wire

>>> sv/hcm_ctrl.sv
`default_nettype none
module hcm_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire hcm_pkg::dp_stat_t  stat,
    output hcm_pkg::ctrl_cmd_t      cmd
);

    hcm_pkg::state_t state_reg;
    hcm_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hcm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hcm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = stat.empty ? hcm_pkg::ST_FINISH : hcm_pkg::ST_READ;
                end
            end
            hcm_pkg::ST_READ:
            begin
                state_next = hcm_pkg::ST_CMP;
            end
            hcm_pkg::ST_CMP:
            begin
                priority if (stat.match)
                begin
                    state_next = stat.op_remove ? hcm_pkg::ST_MOVE_RD : hcm_pkg::ST_FINISH;
                end
                else if (stat.last)
                begin
                    state_next = hcm_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = hcm_pkg::ST_READ;
                end
            end
            hcm_pkg::ST_MOVE_RD:
            begin
                state_next = hcm_pkg::ST_MOVE_WR;
            end
            hcm_pkg::ST_MOVE_WR:
            begin
                state_next = hcm_pkg::ST_FINISH;
            end
            hcm_pkg::ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = hcm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hcm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = (state_reg == hcm_pkg::ST_IDLE);
        cmd.start    = (state_reg == hcm_pkg::ST_IDLE) && in_valid;
        cmd.scan_rd  = (state_reg == hcm_pkg::ST_READ);
        cmd.scan_cmp = (state_reg == hcm_pkg::ST_CMP);
        cmd.move_rd  = (state_reg == hcm_pkg::ST_MOVE_RD);
        cmd.move_wr  = (state_reg == hcm_pkg::ST_MOVE_WR);
        cmd.finish   = (state_reg == hcm_pkg::ST_FINISH) && stat.out_free;
    end

endmodule
`default_nettype wire

>>> sv/hcm_datapath.sv
`default_nettype none
module hcm_datapath #(
    parameter int CAPACITY    = 1024,
    parameter int MAX_BUCKETS = 2048
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire hcm_pkg::ctrl_cmd_t          cmd,
    output hcm_pkg::dp_stat_t                stat,
    input  wire logic                        cfg_we,
    input  wire logic [hcm_pkg::CFG_W-1:0]   cfg_wdata,
    input  wire logic [hcm_pkg::OP_W-1:0]    in_op,
    input  wire logic [hcm_pkg::KEY_W-1:0]   in_key,
    input  wire logic [hcm_pkg::VAL_W-1:0]   in_value,
    input  wire logic                        out_ready,
    output logic                             out_valid,
    output logic [hcm_pkg::ST_W-1:0]         out_status,
    output logic                             out_found,
    output logic [hcm_pkg::VAL_W-1:0]        out_found_value,
    output logic [$clog2(MAX_BUCKETS+1)-1:0] out_bucket_count,
    output logic [$clog2(CAPACITY+1)-1:0]    out_entry_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int BW = $clog2(MAX_BUCKETS + 1);
    localparam int XW = BW + CW;
    localparam int RST_B = (hcm_pkg::RESET_BUCKETS > MAX_BUCKETS) ? MAX_BUCKETS
                                                                  : hcm_pkg::RESET_BUCKETS;

    logic [hcm_pkg::KEY_W-1:0] mem_key [CAPACITY];
    logic [hcm_pkg::VAL_W-1:0] mem_val [CAPACITY];

    logic [hcm_pkg::OP_W-1:0]  op_reg;
    logic [hcm_pkg::KEY_W-1:0] key_reg;
    logic [hcm_pkg::VAL_W-1:0] val_reg;
    logic [AW-1:0]             scan_idx_reg;
    logic [AW-1:0]             pos_reg;
    logic                      hit_reg;
    logic [hcm_pkg::VAL_W-1:0] hit_val_reg;
    logic [hcm_pkg::KEY_W-1:0] rd_key_reg;
    logic [hcm_pkg::VAL_W-1:0] rd_val_reg;
    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;
    logic [BW-1:0]             buckets_reg;
    logic [BW-1:0]             buckets_next;
    logic                      out_valid_reg;

    logic [hcm_pkg::ST_W-1:0]  res_status;
    logic                      res_found;
    logic [hcm_pkg::VAL_W-1:0] res_value;
    logic                      ins_we;
    logic [XW-1:0]             cnt_ext;
    logic [XW-1:0]             b_ext;
    logic [XW-1:0]             dbl;
    logic [BW-1:0]             half;
    logic [AW-1:0]             last_idx;
    logic [AW-1:0]             rd_addr;
    logic                      rd_en;
    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic [hcm_pkg::KEY_W-1:0] wr_key;
    logic [hcm_pkg::VAL_W-1:0] wr_val;
    logic [31:0]               cfg_ext;
    logic [BW-1:0]             cfg_buckets;

    assign last_idx = AW'(count_reg - CW'(1));

    always_comb
    begin
        stat.empty     = (count_reg == '0);
        stat.last      = (CW'(scan_idx_reg) == (count_reg - CW'(1)));
        stat.match     = (rd_key_reg == key_reg);
        stat.op_remove = (op_reg == hcm_pkg::OP_REMOVE);
        stat.out_free  = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        cfg_ext = 32'(cfg_wdata);
        if (cfg_ext == 32'd0)
        begin
            cfg_buckets = BW'(1);
        end
        else if (cfg_ext > 32'(MAX_BUCKETS))
        begin
            cfg_buckets = BW'(MAX_BUCKETS);
        end
        else
        begin
            cfg_buckets = BW'(cfg_ext);
        end
    end

    always_comb
    begin
        cnt_ext      = XW'(count_reg);
        b_ext        = XW'(buckets_reg);
        dbl          = b_ext << 1;
        half         = buckets_reg >> 1;
        res_status   = hcm_pkg::STAT_OK;
        res_found    = 1'b0;
        res_value    = '0;
        ins_we       = 1'b0;
        count_next   = count_reg;
        buckets_next = buckets_reg;
        unique case (op_reg)
            hcm_pkg::OP_INSERT:
            begin
                priority if (hit_reg)
                begin
                    res_status = hcm_pkg::STAT_DUP;
                    res_found  = 1'b1;
                end
                else if (cnt_ext >= XW'(CAPACITY))
                begin
                    res_status = hcm_pkg::STAT_FULL;
                end
                else
                begin
                    ins_we     = 1'b1;
                    count_next = count_reg + CW'(1);
                    if ((cnt_ext + XW'(1)) == b_ext)
                    begin
                        buckets_next = (dbl > XW'(MAX_BUCKETS)) ? BW'(MAX_BUCKETS) : BW'(dbl);
                    end
                end
            end
            hcm_pkg::OP_REMOVE:
            begin
                if (hit_reg)
                begin
                    res_found  = 1'b1;
                    count_next = count_reg - CW'(1);
                    if ((cnt_ext - XW'(1)) <= (b_ext >> 2))
                    begin
                        buckets_next = (half == '0) ? BW'(1) : half;
                    end
                end
                else
                begin
                    res_status = hcm_pkg::STAT_NOTFOUND;
                end
            end
            default:
            begin
                if (hit_reg)
                begin
                    res_found = 1'b1;
                    res_value = hit_val_reg;
                end
                else
                begin
                    res_status = hcm_pkg::STAT_NOTFOUND;
                end
            end
        endcase
    end

    always_comb
    begin
        rd_en   = cmd.scan_rd || cmd.move_rd;
        rd_addr = cmd.scan_rd ? scan_idx_reg : last_idx;
        wr_en   = cmd.move_wr || (cmd.finish && ins_we);
        wr_addr = cmd.move_wr ? pos_reg : count_reg[AW-1:0];
        wr_key  = cmd.move_wr ? rd_key_reg : key_reg;
        wr_val  = cmd.move_wr ? rd_val_reg : val_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_key[wr_addr] <= wr_key;
            mem_val[wr_addr] <= wr_val;
        end
        if (rd_en)
        begin
            rd_key_reg <= mem_key[rd_addr];
            rd_val_reg <= mem_val[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg       <= in_op;
            key_reg      <= in_key;
            val_reg      <= in_value;
            scan_idx_reg <= '0;
            hit_reg      <= 1'b0;
        end
        else if (cmd.scan_cmp)
        begin
            if (stat.match)
            begin
                hit_reg     <= 1'b1;
                pos_reg     <= scan_idx_reg;
                hit_val_reg <= rd_val_reg;
            end
            else
            begin
                scan_idx_reg <= scan_idx_reg + AW'(1);
            end
        end
        if (cmd.finish)
        begin
            out_status       <= res_status;
            out_found        <= res_found;
            out_found_value  <= res_value;
            out_bucket_count <= buckets_next;
            out_entry_count  <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            buckets_reg   <= BW'(RST_B);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                count_reg   <= '0;
                buckets_reg <= cfg_buckets;
            end
            else if (cmd.finish)
            begin
                count_reg   <= count_next;
                buckets_reg <= buckets_next;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(CAPACITY) >= count_reg)
        else $error("entry count above capacity");
    a_buckets_range: assert property (@(posedge clk) disable iff (!rst_n)
        (buckets_reg != '0) && (buckets_reg <= BW'(MAX_BUCKETS)))
        else $error("bucket count out of range");
    a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && hit_reg && (op_reg == hcm_pkg::OP_REMOVE) && !cfg_we)
        |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("remove hit did not drop entry count");
    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || out_ready))
        else $error("result overwritten");
`endif

endmodule
`default_nettype wire

>>> tb/tb_hcm_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface tb_hcm_cfg_if;
    logic                        we;
    logic [hcm_pkg::CFG_W-1:0]   wdata;
endinterface
`default_nettype wire

>>> tb/tb_chained_hash_map_with_resize_core.sv
`timescale 1ns / 1ps
module tb_chained_hash_map_with_resize_core;

    localparam int CAP     = 1024;
    localparam int MAXB    = 2048;
    localparam int LIMIT   = 6000000;

    typedef struct packed {
        logic [hcm_pkg::ST_W-1:0]  status;
        logic                      found;
        logic [hcm_pkg::VAL_W-1:0] fval;
        logic [11:0]               buckets;
        logic [10:0]               entries;
    } map_result_t;

    logic clk;
    logic rst_n;

    tb_hcm_cfg_if cfg ();
    hcm_req_if req ();
    hcm_rsp_if #(.BW($clog2(MAXB + 1)), .CW($clog2(CAP + 1))) rsp ();

    chained_hash_map_with_resize_core #(.CAPACITY(CAP), .MAX_BUCKETS(MAXB)) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg.we),
        .cfg_wdata(cfg.wdata),
        .req      (req.sink),
        .rsp      (rsp.source)
    );

    // predictor state
    logic [hcm_pkg::VAL_W-1:0] map_vals [logic [hcm_pkg::KEY_W-1:0]];
    int unsigned      bucket_now;
    map_result_t      pending_results[$];

    int  err_count;
    int  cyc = 0;
    int  send_idle_pct;
    int  recv_stall_pct;
    logic [hcm_pkg::KEY_W-1:0] key_pool[$];

    initial begin
        clk = 1'b0;
        forever
        begin
            #5 clk = 1'b1;
            #5 clk = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc > LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int unsigned clamp_b(int unsigned b);
        if (b < 1) return 1;
        if (b > MAXB) return MAXB;
        return b;
    endfunction

    function automatic map_result_t predict_map(logic [hcm_pkg::OP_W-1:0] op,
                                                logic [hcm_pkg::KEY_W-1:0] k,
                                                logic [hcm_pkg::VAL_W-1:0] v);
        map_result_t r;
        logic hit;
        r = '0;
        hit = map_vals.exists(k);
        if (op == hcm_pkg::OP_INSERT)
        begin
            if (hit)
            begin
                r.status = hcm_pkg::STAT_DUP;
                r.found = 1'b1;
            end
            else if (map_vals.num() >= CAP)
                r.status = hcm_pkg::STAT_FULL;
            else
            begin
                map_vals[k] = v;
                r.status = hcm_pkg::STAT_OK;
                if (map_vals.num() == bucket_now)
                    bucket_now = clamp_b(bucket_now * 2);
            end
        end
        else if (op == hcm_pkg::OP_REMOVE)
        begin
            if (!hit)
                r.status = hcm_pkg::STAT_NOTFOUND;
            else
            begin
                r.found = 1'b1;
                map_vals.delete(k);
                if (map_vals.num() <= bucket_now / 4)
                    bucket_now = clamp_b(bucket_now / 2);
            end
        end
        else
        begin
            if (!hit)
                r.status = hcm_pkg::STAT_NOTFOUND;
            else
            begin
                r.found = 1'b1;
                r.fval = map_vals[k];
            end
        end
        r.buckets = bucket_now[11:0];
        r.entries = 11'(map_vals.num());
        return r;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        map_result_t want;
        map_result_t got;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got = {rsp.status, rsp.found, rsp.found_value, rsp.bucket_count, rsp.entry_count};
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $realtime, got);
                err_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (want.status !== got.status)
                begin
                    $display("%0t: status exp %0d got %0d", $realtime, want.status, got.status);
                    err_count++;
                end
                if (want.found !== got.found)
                begin
                    $display("%0t: found exp %0d got %0d", $realtime, want.found, got.found);
                    err_count++;
                end
                if (want.fval !== got.fval)
                begin
                    $display("%0t: found_value exp %h got %h", $realtime, want.fval, got.fval);
                    err_count++;
                end
                if (want.buckets !== got.buckets)
                begin
                    $display("%0t: bucket_count exp %0d got %0d", $realtime, want.buckets,
                             got.buckets);
                    err_count++;
                end
                if (want.entries !== got.entries)
                begin
                    $display("%0t: entry_count exp %0d got %0d", $realtime, want.entries,
                             got.entries);
                    err_count++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct)
            rsp.ready <= 1'b0;
        else
            rsp.ready <= 1'b1;
    end

    // called and returns at a falling edge; valid stays up until the next item or idle
    task automatic send_item(logic [hcm_pkg::OP_W-1:0] op, logic [hcm_pkg::KEY_W-1:0] k,
                             logic [hcm_pkg::VAL_W-1:0] v);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid <= 1'b1;
        req.op    <= op;
        req.key   <= k;
        req.value <= v;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        pending_results.push_back(predict_map(op, k, v));
        @(negedge clk);
    endtask

    task automatic drain_results();
        req.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_buckets(logic [hcm_pkg::CFG_W-1:0] b);
        drain_results();
        cfg.we    <= 1'b1;
        cfg.wdata <= b;
        @(negedge clk);
        cfg.we <= 1'b0;
        map_vals.delete();
        key_pool.delete();
        bucket_now = clamp_b(b);
    endtask

    task automatic test_directed();
        send_item(hcm_pkg::OP_LOOKUP, 31'h7FFF_FFFF, '1);
        send_item(hcm_pkg::OP_REMOVE, 31'd0, 32'd0);
        send_item(hcm_pkg::OP_INSERT, 31'd0, 32'hFFFF_FFFF);
        send_item(hcm_pkg::OP_INSERT, 31'h7FFF_FFFF, 32'd0);
        send_item(hcm_pkg::OP_INSERT, 31'h5555_5555, 32'hAAAA_AAAA);
        send_item(hcm_pkg::OP_INSERT, 31'h2AAA_AAAA, 32'h5555_5555);
        send_item(hcm_pkg::OP_INSERT, 31'd0, 32'h1234_5678);
        send_item(hcm_pkg::OP_LOOKUP, 31'd0, 32'd0);
        send_item(hcm_pkg::OP_LOOKUP, 31'h7FFF_FFFF, 32'd9);
        send_item(2'd3, 31'h5555_5555, 32'd0);
        send_item(2'd3, 31'd77, 32'd0);
        send_item(hcm_pkg::OP_REMOVE, 31'h5555_5555, 32'd0);
        send_item(hcm_pkg::OP_REMOVE, 31'h5555_5555, 32'd0);
        send_item(hcm_pkg::OP_REMOVE, 31'd0, 32'd0);
        send_item(hcm_pkg::OP_REMOVE, 31'h7FFF_FFFF, 32'd0);
        send_item(hcm_pkg::OP_REMOVE, 31'h2AAA_AAAA, 32'd0);
    endtask

    task automatic test_bucket_floor();
        write_buckets(12'd0);
        send_item(hcm_pkg::OP_INSERT, 31'd5, 32'd1);
        send_item(hcm_pkg::OP_INSERT, 31'd6, 32'd2);
        send_item(hcm_pkg::OP_REMOVE, 31'd5, 32'd0);
        send_item(hcm_pkg::OP_REMOVE, 31'd6, 32'd0);
        send_item(hcm_pkg::OP_REMOVE, 31'd6, 32'd0);
    endtask

    task automatic test_large_store();
        int i;
        write_buckets(12'd4095);
        for (i = 0; i < 100; i++)
            send_item(hcm_pkg::OP_INSERT, i[hcm_pkg::KEY_W-1:0] * 31'd7919, {$urandom});
        send_item(hcm_pkg::OP_INSERT, 31'h7FFF_FFFE, 32'd3);
        send_item(hcm_pkg::OP_INSERT, 31'd0, 32'd3);
        send_item(hcm_pkg::OP_LOOKUP, 31'd7919, 32'd0);
        for (i = 0; i < 40; i++)
            send_item(hcm_pkg::OP_REMOVE, i[hcm_pkg::KEY_W-1:0] * 31'd7919, 32'd0);
    endtask

    task automatic test_random(int n, logic [hcm_pkg::CFG_W-1:0] b);
        int i;
        int sel;
        logic [hcm_pkg::KEY_W-1:0] k;
        write_buckets(b);
        for (i = 0; i < n; i++)
        begin
            sel = $urandom_range(99);
            if (key_pool.size() == 0 || sel < 15)
                k = hcm_pkg::KEY_W'($urandom);
            else
                k = key_pool[$urandom_range(key_pool.size() - 1)];
            sel = $urandom_range(99);
            if (sel < 45)
            begin
                send_item(hcm_pkg::OP_INSERT, k, {$urandom});
                if (key_pool.size() < 64)
                    key_pool.push_back(k);
            end
            else if (sel < 75)
                send_item(hcm_pkg::OP_REMOVE, k, {$urandom});
            else
                send_item(hcm_pkg::OP_LOOKUP | 2'($urandom_range(1)), k, {$urandom});
        end
    endtask

    initial begin
        err_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        bucket_now = hcm_pkg::RESET_BUCKETS;
        rst_n = 1'b0;
        cfg.we = 1'b0;
        cfg.wdata = '0;
        req.valid = 1'b0;
        req.op = hcm_pkg::OP_INSERT;
        req.key = '0;
        req.value = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_bucket_floor();
        test_large_store();
        test_random(110, 12'd2);
        send_idle_pct = 63;
        test_random(110, 12'd2048);
        send_idle_pct = 0;
        recv_stall_pct = 63;
        test_random(110, 12'd1);
        send_idle_pct = 31;
        recv_stall_pct = 31;
        test_random(110, 12'd4);
        drain_results();

        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

>>> filelist.f
sv/hcm_pkg.sv
sv/hcm_req_if.sv
sv/hcm_rsp_if.sv
sv/hcm_ctrl.sv
sv/hcm_datapath.sv
sv/chained_hash_map_with_resize_core.sv
tb/tb_hcm_if.sv
tb/tb_chained_hash_map_with_resize_core.sv
